/* hw/rtl/hlls_pkg.sv */
// Shared constants, types and helper functions for the HyperLogLog register sketch.
// No dependencies; every other file imports this package.
package hlls_pkg;

   localparam int unsigned MAX_PRECISION = 14;
   localparam int unsigned MIN_PRECISION = 4;
   localparam int unsigned ADDR_W        = MAX_PRECISION;
   localparam int unsigned CNT_W         = ADDR_W + 1;
   localparam int unsigned VAL_W         = 6;
   localparam int unsigned HASH_W        = 64;
   localparam int unsigned SUM_W         = 64;
   localparam int unsigned PREC_W        = 4;
   localparam int unsigned FUNC_W        = 2;
   localparam int unsigned CLZ_W         = 7;
   localparam logic [VAL_W-1:0] FRAC_BITS = VAL_W'(49);

   localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_MERGE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

   // query walker to top level: memory read request and completion
   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              done;
   } qry_stat_type;

   function automatic logic [PREC_W-1:0] clamp_precision(input logic [PREC_W-1:0] v);
      logic [PREC_W-1:0] r;
      r = v;
      if (v < PREC_W'(MIN_PRECISION)) r = PREC_W'(MIN_PRECISION);
      if (v > PREC_W'(MAX_PRECISION)) r = PREC_W'(MAX_PRECISION);
      return r;
   endfunction

   // leading zeros of a 64-bit word: per-byte counts, then first non-empty byte
   function automatic logic [CLZ_W-1:0] clz64(input logic [HASH_W-1:0] v);
      logic [3:0]       bclz [8];
      logic [CLZ_W-1:0] n;
      logic             found;
      for (int b = 0; b < 8; b++) begin
         bclz[b] = 4'd8;
         for (int i = 0; i < 8; i++) begin
            if (v[8*b+i]) bclz[b] = 4'(7 - i);
         end
      end
      n     = CLZ_W'(HASH_W);
      found = 1'b0;
      for (int b = 7; b >= 0; b--) begin
         if (!found && bclz[b] != 4'd8) begin
            n     = CLZ_W'((7 - b) * 8) + CLZ_W'(bclz[b]);
            found = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

/* hw/rtl/hlls_ram.sv */
// Register store: one write port, one read port, registered read data.
// Depends on hlls_pkg for depth and widths.
module hlls_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [hlls_pkg::ADDR_W-1:0] wr_addr,
   input  logic [hlls_pkg::VAL_W-1:0]  wr_data,
   input  logic                       rd_en,
   input  logic [hlls_pkg::ADDR_W-1:0] rd_addr,
   output logic [hlls_pkg::VAL_W-1:0]  rd_data
);
   import hlls_pkg::*;

   logic [VAL_W-1:0] rank_mem_ff [2**ADDR_W];
   logic [VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rank_mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rank_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/hlls_hash_unit.sv */
// Splits an added hash into register index and rank.
// Depends on hlls_pkg for widths and the leading-zero count.
module hlls_hash_unit (
   input  logic [hlls_pkg::HASH_W-1:0] hash_value,
   input  logic [hlls_pkg::PREC_W-1:0] precision,
   output logic [hlls_pkg::ADDR_W-1:0] reg_index,
   output logic [hlls_pkg::VAL_W-1:0]  rank
);
   import hlls_pkg::*;

   logic [HASH_W-1:0] masked;
   logic [CLZ_W-1:0]  lz;
   logic [CLZ_W-1:0]  rank_wide;

   // top precision bits pick the register
   assign reg_index = hash_value[HASH_W-1 -: ADDR_W] >> (PREC_W'(MAX_PRECISION) - precision);

   // leading zeros below the index bits; all zero gives the cap 65-precision
   assign masked    = hash_value & ({HASH_W{1'b1}} >> precision);
   assign lz        = clz64(masked);
   assign rank_wide = lz + CLZ_W'(1) - CLZ_W'(precision);
   assign rank      = rank_wide[VAL_W-1:0];

endmodule

/* hw/rtl/hlls_query.sv */
// Query walker: reads every active register once and accumulates the
// zero count and the Q15.49 harmonic sum. Depends on hlls_pkg.
module hlls_query (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [hlls_pkg::CNT_W-1:0]   size,
   input  logic [hlls_pkg::VAL_W-1:0]   rd_data,
   output hlls_pkg::qry_stat_type       stat,
   output logic [hlls_pkg::SUM_W-1:0]   sum,
   output logic [hlls_pkg::CNT_W-1:0]   zeros
);
   import hlls_pkg::*;

   logic [CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic             issuing_ff, issuing_in;
   logic             rv_ff, rv_in;
   logic             last_ff, last_in;
   logic             done_ff, done_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] zeros_ff, zeros_in;
   logic             last_issue;
   logic [SUM_W-1:0] term;

   assign last_issue = (issue_cnt_ff == size - CNT_W'(1));

   // values above the fraction width fall below one LSB
   assign term = (rd_data <= FRAC_BITS) ? (SUM_W'(1) << (FRAC_BITS - rd_data)) : '0;

   always_comb begin
      issue_cnt_in = issue_cnt_ff;
      issuing_in   = issuing_ff;
      rv_in        = issuing_ff;
      last_in      = issuing_ff && last_issue;
      done_in      = done_ff;
      sum_in       = sum_ff;
      zeros_in     = zeros_ff;
      if (issuing_ff) begin
         issue_cnt_in = issue_cnt_ff + CNT_W'(1);
         if (last_issue) issuing_in = 1'b0;
      end
      if (rv_ff) begin
         sum_in = sum_ff + term;
         if (rd_data == '0) zeros_in = zeros_ff + CNT_W'(1);
         if (last_ff) done_in = 1'b1;
      end
      if (start) begin
         issue_cnt_in = '0;
         issuing_in   = 1'b1;
         done_in      = 1'b0;
         sum_in       = '0;
         zeros_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         rv_ff      <= 1'b0;
         last_ff    <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         issuing_ff <= issuing_in;
         rv_ff      <= rv_in;
         last_ff    <= last_in;
         done_ff    <= done_in;
      end
      issue_cnt_ff <= issue_cnt_in;
      sum_ff       <= sum_in;
      zeros_ff     <= zeros_in;
   end

   assign stat.rd_en   = issuing_ff;
   assign stat.rd_addr = issue_cnt_ff[ADDR_W-1:0];
   assign stat.done    = done_ff;
   assign sum          = sum_ff;
   assign zeros        = zeros_ff;

endmodule

/* hw/rtl/hyperloglog_register_sketch.sv */
// HyperLogLog register sketch: 2^precision six-bit registers in one on-chip memory.
// Adds and merges sustain one item per clock while responses are taken: an item
// reads its register on acceptance and writes the updated value from the update
// stage, with the last write forwarded so back-to-back hits on the same register
// stay exact. A query reads every active register through the single read port and
// presents its result once the walk is done; no item is taken meanwhile. After
// reset the whole store is cleared, and after each precision write the 2^precision
// active registers; items are held off meanwhile. Depends on hlls_pkg, hlls_ram,
// hlls_hash_unit and hlls_query.
module hyperloglog_register_sketch (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [hlls_pkg::FUNC_W-1:0]   req_func,
   input  logic [hlls_pkg::HASH_W-1:0]   req_hash_value,
   input  logic [hlls_pkg::ADDR_W-1:0]   req_reg_index,
   input  logic [hlls_pkg::VAL_W-1:0]    req_reg_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hlls_pkg::SUM_W-1:0]    rsp_harmonic_sum,
   output logic [hlls_pkg::CNT_W-1:0]    rsp_zero_count,
   output logic                          rsp_is_query_result,
   output logic                          rsp_index_error,
   input  logic                          csr_wr_en,
   input  logic [hlls_pkg::PREC_W-1:0]   csr_wr_data
);
   import hlls_pkg::*;

   typedef enum logic [1:0] {ST_CLEAR, ST_RUN, ST_WALK} state_type;

   state_type         state_ff, state_in;
   logic [PREC_W-1:0] precision_ff, precision_in;
   logic [CNT_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic [CNT_W-1:0]  size;

   // update stage
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_wr_ok_ff, s1_wr_ok_in;
   logic              s1_err_ff, s1_err_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic [VAL_W-1:0]  s1_val_ff, s1_val_in;

   // last write, forwarded to a read of the same register
   logic              fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0] fwd_addr_ff, fwd_addr_in;
   logic [VAL_W-1:0]  fwd_data_ff, fwd_data_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]  rsp_sum_ff, rsp_sum_in;
   logic [CNT_W-1:0]  rsp_zeros_ff, rsp_zeros_in;
   logic              rsp_query_ff, rsp_query_in;
   logic              rsp_err_ff, rsp_err_in;

   logic              out_free, s1_go, accept, is_query, do_wr, merge_err, q_start;
   logic [VAL_W-1:0]  cur_val;
   logic [ADDR_W-1:0] hu_index;
   logic [VAL_W-1:0]  hu_rank;

   logic              mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [VAL_W-1:0]  mem_wr_data, mem_rd_data;

   qry_stat_type      q_stat;
   logic [SUM_W-1:0]  q_sum;
   logic [CNT_W-1:0]  q_zeros;

   hlls_hash_unit u_hash (
      .hash_value (req_hash_value),
      .precision  (precision_ff),
      .reg_index  (hu_index),
      .rank       (hu_rank)
   );

   hlls_query u_query (
      .clock   (clock),
      .reset   (reset),
      .start   (q_start),
      .size    (size),
      .rd_data (mem_rd_data),
      .stat    (q_stat),
      .sum     (q_sum),
      .zeros   (q_zeros)
   );

   hlls_ram u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign size      = CNT_W'(1) << precision_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && out_free;
   assign req_ready = (state_ff == ST_RUN) && (!s1_valid_ff || s1_go);
   assign accept    = req_valid && req_ready;
   assign is_query  = (req_func == FUNC_QUERY);
   assign q_start   = accept && is_query;
   assign merge_err = (CNT_W'(req_reg_index) >> precision_ff) != '0;

   assign cur_val = (fwd_valid_ff && fwd_addr_ff == s1_addr_ff) ? fwd_data_ff : mem_rd_data;
   assign do_wr   = s1_go && s1_wr_ok_ff && (s1_val_ff > cur_val);

   always_comb begin
      s1_wr_ok_in = 1'b0;
      s1_err_in   = 1'b0;
      s1_addr_in  = req_reg_index;
      s1_val_in   = req_reg_value;
      case (req_func)
         FUNC_ADD: begin
            s1_wr_ok_in = 1'b1;
            s1_addr_in  = hu_index;
            s1_val_in   = hu_rank;
         end
         FUNC_MERGE: begin
            s1_err_in   = merge_err;
            s1_wr_ok_in = !merge_err;
         end
         default: begin
            s1_wr_ok_in = 1'b0;
         end
      endcase
      s1_valid_in = s1_valid_ff && !s1_go;
      if (accept && !is_query) s1_valid_in = 1'b1;
   end

   always_comb begin
      mem_rd_en   = q_stat.rd_en || (accept && !is_query);
      mem_rd_addr = q_stat.rd_en ? q_stat.rd_addr : s1_addr_in;
      if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_cnt_ff[ADDR_W-1:0];
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = do_wr;
         mem_wr_addr = s1_addr_ff;
         mem_wr_data = s1_val_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      precision_in = precision_ff;
      clr_cnt_in   = clr_cnt_ff;
      fwd_valid_in = fwd_valid_ff;
      fwd_addr_in  = fwd_addr_ff;
      fwd_data_in  = fwd_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_zeros_in = rsp_zeros_ff;
      rsp_query_in = rsp_query_ff;
      rsp_err_in   = rsp_err_ff;

      if (do_wr) begin
         fwd_valid_in = 1'b1;
         fwd_addr_in  = s1_addr_ff;
         fwd_data_in  = s1_val_ff;
      end

      if (s1_go) begin
         rsp_valid_in = 1'b1;
         rsp_sum_in   = '0;
         rsp_zeros_in = '0;
         rsp_query_in = 1'b0;
         rsp_err_in   = s1_err_ff;
      end

      case (state_ff)
         ST_CLEAR: begin
            fwd_valid_in = 1'b0;
            clr_cnt_in   = clr_cnt_ff + CNT_W'(1);
            if (clr_cnt_ff == size - CNT_W'(1)) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (q_start) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (q_stat.done && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = q_sum;
               rsp_zeros_in = q_zeros;
               rsp_query_in = 1'b1;
               rsp_err_in   = 1'b0;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase

      // a precision write restarts the clearing pass
      if (csr_wr_en) begin
         precision_in = clamp_precision(csr_wr_data);
         clr_cnt_in   = '0;
         state_in     = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         precision_ff <= PREC_W'(MAX_PRECISION);
         clr_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         precision_ff <= precision_in;
         clr_cnt_ff   <= clr_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         s1_wr_ok_ff <= s1_wr_ok_in;
         s1_err_ff   <= s1_err_in;
         s1_addr_ff  <= s1_addr_in;
         s1_val_ff   <= s1_val_in;
      end
      fwd_addr_ff  <= fwd_addr_in;
      fwd_data_ff  <= fwd_data_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_zeros_ff <= rsp_zeros_in;
      rsp_query_ff <= rsp_query_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_harmonic_sum    = rsp_sum_ff;
   assign rsp_zero_count      = rsp_zeros_ff;
   assign rsp_is_query_result = rsp_query_ff;
   assign rsp_index_error     = rsp_err_ff;

endmodule
